// ===== rtl/bilinear_map_interpolator_macros.svh =====
// Assertion macros shared by the bilinear map interpolator RTL.
`ifndef BILINEAR_MAP_INTERPOLATOR_MACROS_SVH
`define BILINEAR_MAP_INTERPOLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define BMI_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bilinear map interpolator assertion failed");
`define BMI_ASSERT_NEVER(label, cond) \
   `BMI_ASSERT(label, !(cond))
`else
`define BMI_ASSERT(label, prop)
`define BMI_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== rtl/bmi_pkg.sv =====
// Types and constants of the bilinear map interpolator.
package bmi_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_X    = 2'd0,
      CMD_WRITE_Y    = 2'd1,
      CMD_WRITE_CELL = 2'd2,
      CMD_LOOKUP     = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_INSIDE   = 2'd0;
   localparam logic [1:0] STATUS_CLAMPED  = 2'd1;
   localparam logic [1:0] STATUS_EQUAL_BP = 2'd2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_POINTS_USED = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_POINTS_USED = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  POINTS_USED_RESET = 4'd5;

   localparam int COORD_W  = 16;
   localparam int CELL_W   = 16;
   localparam int RESULT_W = 24;
   // Quotient, numerator and denominator widths of the rounding division.
   localparam int QUOT_W   = 24;
   localparam int DEN_W    = 2 * COORD_W;
   localparam int MAG_W    = 48;
   localparam int NUM_W    = 56;
   // Edges from the accepting edge to the edge that takes the result.
   localparam int LATENCY  = 8 + QUOT_W;

   typedef struct packed {
      logic       neg;
      logic [1:0] status;
   } div_tag_type;

endpackage

// ===== rtl/bmi_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module bmi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // A read at the written address returns the old contents.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

// ===== rtl/bmi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`include "bilinear_map_interpolator_macros.svh"
module bmi_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [bmi_pkg::NUM_W-1:0]      in_num,
   input  logic [bmi_pkg::DEN_W-1:0]      in_den,
   input  bmi_pkg::div_tag_type           in_tag,
   output logic                           out_valid,
   output logic [bmi_pkg::QUOT_W-1:0]     out_quot,
   output bmi_pkg::div_tag_type           out_tag
);

   localparam int QW = bmi_pkg::QUOT_W;
   localparam int NW = bmi_pkg::NUM_W;
   localparam int DW = bmi_pkg::DEN_W;

   logic                 valid_ff [QW];
   logic [NW-1:0]        rem_ff   [QW];
   logic [DW-1:0]        den_ff   [QW];
   logic [QW-1:0]        quot_ff  [QW];
   bmi_pkg::div_tag_type tag_ff   [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic                 valid_src;
      logic [NW-1:0]        rem_src;
      logic [DW-1:0]        den_src;
      logic [QW-1:0]        quot_src;
      bmi_pkg::div_tag_type tag_src;
      logic [NW:0]          shifted;
      logic [NW:0]          diff;

      if (j == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_num;
         assign den_src   = in_den;
         assign quot_src  = '0;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign den_src   = den_ff[j-1];
         assign quot_src  = quot_ff[j-1];
         assign tag_src   = tag_ff[j-1];
      end

      // Stage j decides quotient bit QW-1-j.
      assign shifted = (NW+1)'(den_src) << (QW - 1 - j);
      assign diff    = {1'b0, rem_src} - shifted;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[j] <= den_src;
         tag_ff[j] <= tag_src;
         if (!diff[NW]) begin
            rem_ff[j]  <= diff[NW-1:0];
            quot_ff[j] <= quot_src | (QW'(1) << (QW - 1 - j));
         end else begin
            rem_ff[j]  <= rem_src;
            quot_ff[j] <= quot_src;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

   // The quotient must fit in QW bits, and the last remainder must be below the divisor.
   `BMI_ASSERT(a_num_fits, in_valid |-> ({1'b0, in_num} < ((NW+1)'(in_den) << QW)))
   `BMI_ASSERT(a_rem_below_den, valid_ff[QW-1] |-> (rem_ff[QW-1] < NW'(den_ff[QW-1])))

endmodule

// ===== rtl/bilinear_map_interpolator.sv =====
// Bilinear map interpolator: breakpoint search, blend and rounding division.
// Throughput: one transaction per cycle; busy stays low, the receiver cannot stall.
// The pipeline is seven front stages, the divider's 24 stages and the output register.
// Reset clears the pipeline valid bits and sets both point counts to 5;
// breakpoints and map cells are not cleared and hold nothing until written.
`include "bilinear_map_interpolator_macros.svh"
module bilinear_map_interpolator #(
   parameter int X_POINTS = 8,
   parameter int Y_POINTS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_command,
   input  logic [2:0]                              req_column,
   input  logic [2:0]                              req_row,
   input  logic signed [16:0]                      req_write_value,
   input  logic [bmi_pkg::COORD_W-1:0]             req_query_x,
   input  logic [bmi_pkg::COORD_W-1:0]             req_query_y,
   output logic                                    rsp_valid,
   output logic signed [bmi_pkg::RESULT_W-1:0]     rsp_interpolated,
   output logic [1:0]                              rsp_status,
   input  logic                                    csr_write_enable,
   input  logic [bmi_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [bmi_pkg::CSR_DATA_W-1:0]          csr_write_data
);

   localparam int XW = $clog2(X_POINTS);
   localparam int YW = $clog2(Y_POINTS);
   localparam int AW = $clog2(X_POINTS * Y_POINTS);
   localparam int CW = bmi_pkg::COORD_W;
   localparam int VW = bmi_pkg::CELL_W;
   localparam int PW = CW + VW + 1;
   localparam int TW = PW + CW;
   localparam int SW = TW + 2;

   // Configuration registers.
   logic [bmi_pkg::CSR_DATA_W-1:0] x_used_ff;
   logic [bmi_pkg::CSR_DATA_W-1:0] y_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_used_ff <= bmi_pkg::POINTS_USED_RESET;
         y_used_ff <= bmi_pkg::POINTS_USED_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == bmi_pkg::CSR_X_POINTS_USED) begin
            x_used_ff <= csr_write_data;
         end
         if (csr_index == bmi_pkg::CSR_Y_POINTS_USED) begin
            y_used_ff <= csr_write_data;
         end
      end
   end

   assign busy = 1'b0;

   // Stage 0: input register.
   logic             s0_valid_ff;
   bmi_pkg::cmd_type s0_cmd_ff;
   logic [2:0]       s0_col_ff;
   logic [2:0]       s0_row_ff;
   logic [VW-1:0]    s0_wv_ff;
   logic [CW-1:0]    s0_qx_ff;
   logic [CW-1:0]    s0_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_cmd_ff <= bmi_pkg::cmd_type'(req_command);
      s0_col_ff <= req_column;
      s0_row_ff <= req_row;
      s0_wv_ff  <= req_write_value[VW-1:0];
      s0_qx_ff  <= req_query_x;
      s0_qy_ff  <= req_query_y;
   end

   // Stage 1: breakpoint search. Breakpoint writes land here, in transaction order.
   logic [CW-1:0] xbp_ff [X_POINTS];
   logic [CW-1:0] ybp_ff [Y_POINTS];
   logic [XW:0]   x_count;
   logic [YW:0]   y_count;
   logic [XW-1:0] x_last;
   logic [YW-1:0] y_last;
   logic [XW-1:0] x_lo_in;
   logic [YW-1:0] y_lo_in;
   logic [XW-1:0] x_hi_idx;
   logic [YW-1:0] y_hi_idx;
   logic          clamp_in;

   always_comb begin
      if (x_used_ff < 2) begin
         x_count = (XW+1)'(2);
      end else if (x_used_ff > X_POINTS) begin
         x_count = (XW+1)'(X_POINTS);
      end else begin
         x_count = (XW+1)'(x_used_ff);
      end
      if (y_used_ff < 2) begin
         y_count = (YW+1)'(2);
      end else if (y_used_ff > Y_POINTS) begin
         y_count = (YW+1)'(Y_POINTS);
      end else begin
         y_count = (YW+1)'(y_used_ff);
      end
      x_last = XW'(x_count - 1'b1);
      y_last = YW'(y_count - 1'b1);
   end

   // The lower index is the last used breakpoint, short of the top one, at or below the query.
   always_comb begin
      x_lo_in = '0;
      for (int k = 1; k < X_POINTS - 1; k++) begin
         if (k + 1 < x_count && xbp_ff[k] <= s0_qx_ff) begin
            x_lo_in = XW'(k);
         end
      end
      y_lo_in = '0;
      for (int k = 1; k < Y_POINTS - 1; k++) begin
         if (k + 1 < y_count && ybp_ff[k] <= s0_qy_ff) begin
            y_lo_in = YW'(k);
         end
      end
      x_hi_idx = x_lo_in + 1'b1;
      y_hi_idx = y_lo_in + 1'b1;
      clamp_in = (s0_qx_ff < xbp_ff[0]) || (s0_qx_ff > xbp_ff[x_last])
              || (s0_qy_ff < ybp_ff[0]) || (s0_qy_ff > ybp_ff[y_last]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < X_POINTS; k++) begin
         if (s0_valid_ff && s0_cmd_ff == bmi_pkg::CMD_WRITE_X && int'(s0_col_ff) == k) begin
            xbp_ff[k] <= s0_wv_ff;
         end
      end
      for (int k = 0; k < Y_POINTS; k++) begin
         if (s0_valid_ff && s0_cmd_ff == bmi_pkg::CMD_WRITE_Y && int'(s0_row_ff) == k) begin
            ybp_ff[k] <= s0_wv_ff;
         end
      end
   end

   logic             s1_valid_ff;
   bmi_pkg::cmd_type s1_cmd_ff;
   logic [2:0]       s1_col_ff;
   logic [2:0]       s1_row_ff;
   logic [VW-1:0]    s1_wv_ff;
   logic [CW-1:0]    s1_qx_ff;
   logic [CW-1:0]    s1_qy_ff;
   logic [XW-1:0]    s1_xi_ff;
   logic [YW-1:0]    s1_yi_ff;
   logic [CW-1:0]    s1_xlo_ff;
   logic [CW-1:0]    s1_xhi_ff;
   logic [CW-1:0]    s1_ylo_ff;
   logic [CW-1:0]    s1_yhi_ff;
   logic             s1_clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= s0_cmd_ff;
      s1_col_ff   <= s0_col_ff;
      s1_row_ff   <= s0_row_ff;
      s1_wv_ff    <= s0_wv_ff;
      s1_qx_ff    <= s0_qx_ff;
      s1_qy_ff    <= s0_qy_ff;
      s1_xi_ff    <= x_lo_in;
      s1_yi_ff    <= y_lo_in;
      s1_xlo_ff   <= xbp_ff[x_lo_in];
      s1_xhi_ff   <= xbp_ff[x_hi_idx];
      s1_ylo_ff   <= ybp_ff[y_lo_in];
      s1_yhi_ff   <= ybp_ff[y_hi_idx];
      s1_clamp_ff <= clamp_in;
   end

   // Stage 2: segment weights and corner cell reads. Cell writes land here.
   logic          x_degen;
   logic          y_degen;
   logic [CW-1:0] x_span;
   logic [CW-1:0] y_span;
   logic [CW-1:0] x_pos;
   logic [CW-1:0] y_pos;
   logic [CW-1:0] wx0_in;
   logic [CW-1:0] wx1_in;
   logic [CW-1:0] wy0_in;
   logic [CW-1:0] wy1_in;
   logic [CW-1:0] dx_in;
   logic [CW-1:0] dy_in;
   logic [1:0]    status_in;

   always_comb begin
      x_degen = s1_xhi_ff <= s1_xlo_ff;
      y_degen = s1_yhi_ff <= s1_ylo_ff;
      x_span  = s1_xhi_ff - s1_xlo_ff;
      y_span  = s1_yhi_ff - s1_ylo_ff;
      x_pos   = (s1_qx_ff > s1_xlo_ff) ? s1_qx_ff - s1_xlo_ff : '0;
      y_pos   = (s1_qy_ff > s1_ylo_ff) ? s1_qy_ff - s1_ylo_ff : '0;
      if (x_pos > x_span) begin
         x_pos = x_span;
      end
      if (y_pos > y_span) begin
         y_pos = y_span;
      end
      // A flat or descending segment puts all weight on the lower cell.
      if (x_degen) begin
         dx_in  = CW'(1);
         wx0_in = CW'(1);
         wx1_in = '0;
      end else begin
         dx_in  = x_span;
         wx0_in = x_span - x_pos;
         wx1_in = x_pos;
      end
      if (y_degen) begin
         dy_in  = CW'(1);
         wy0_in = CW'(1);
         wy1_in = '0;
      end else begin
         dy_in  = y_span;
         wy0_in = y_span - y_pos;
         wy1_in = y_pos;
      end
      if (x_degen || y_degen) begin
         status_in = bmi_pkg::STATUS_EQUAL_BP;
      end else if (s1_clamp_ff) begin
         status_in = bmi_pkg::STATUS_CLAMPED;
      end else begin
         status_in = bmi_pkg::STATUS_INSIDE;
      end
   end

   logic [AW-1:0] row0_base;
   logic [AW-1:0] row1_base;
   logic [AW-1:0] rd_addr [4];
   logic [AW-1:0] cell_wr_addr;
   logic          cell_wr_en;
   logic [VW-1:0] cell_rd [4];

   assign row0_base    = AW'(int'(s1_yi_ff) * X_POINTS);
   assign row1_base    = AW'((int'(s1_yi_ff) + 1) * X_POINTS);
   assign rd_addr[0]   = row0_base + AW'(s1_xi_ff);
   assign rd_addr[1]   = row0_base + AW'(s1_xi_ff) + 1'b1;
   assign rd_addr[2]   = row1_base + AW'(s1_xi_ff);
   assign rd_addr[3]   = row1_base + AW'(s1_xi_ff) + 1'b1;
   assign cell_wr_addr = AW'(int'(s1_row_ff) * X_POINTS + int'(s1_col_ff));
   assign cell_wr_en   = s1_valid_ff && s1_cmd_ff == bmi_pkg::CMD_WRITE_CELL
                      && int'(s1_col_ff) < X_POINTS && int'(s1_row_ff) < Y_POINTS;

   // One copy of the map per corner, so all four corners are read in the same cycle.
   for (genvar c = 0; c < 4; c++) begin : g_map
      bmi_ram #(
         .WIDTH (VW),
         .DEPTH (X_POINTS * Y_POINTS)
      ) u_map (
         .clock   (clock),
         .wr_en   (cell_wr_en),
         .wr_addr (cell_wr_addr),
         .wr_data (s1_wv_ff),
         .rd_addr (rd_addr[c]),
         .rd_data (cell_rd[c])
      );
   end

   logic          s2_valid_ff;
   logic [CW-1:0] s2_wx0_ff;
   logic [CW-1:0] s2_wx1_ff;
   logic [CW-1:0] s2_wy0_ff;
   logic [CW-1:0] s2_wy1_ff;
   logic [CW-1:0] s2_dx_ff;
   logic [CW-1:0] s2_dy_ff;
   logic [1:0]    s2_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_cmd_ff == bmi_pkg::CMD_LOOKUP;
      end
   end

   always_ff @(posedge clock) begin
      s2_wx0_ff    <= wx0_in;
      s2_wx1_ff    <= wx1_in;
      s2_wy0_ff    <= wy0_in;
      s2_wy1_ff    <= wy1_in;
      s2_dx_ff     <= dx_in;
      s2_dy_ff     <= dy_in;
      s2_status_ff <= status_in;
   end

   // Stage 3: cells times x weights, and the denominator.
   logic signed [PW-1:0] p_in [4];
   logic signed [PW-1:0] s3_p_ff [4];
   logic [CW-1:0]        s3_wy0_ff;
   logic [CW-1:0]        s3_wy1_ff;
   logic [2*CW-1:0]      s3_den_ff;
   logic [1:0]           s3_status_ff;
   logic                 s3_valid_ff;

   always_comb begin
      p_in[0] = $signed({{(PW-VW){cell_rd[0][VW-1]}}, cell_rd[0]})
              * $signed({{(PW-CW){1'b0}}, s2_wx0_ff});
      p_in[1] = $signed({{(PW-VW){cell_rd[1][VW-1]}}, cell_rd[1]})
              * $signed({{(PW-CW){1'b0}}, s2_wx1_ff});
      p_in[2] = $signed({{(PW-VW){cell_rd[2][VW-1]}}, cell_rd[2]})
              * $signed({{(PW-CW){1'b0}}, s2_wx0_ff});
      p_in[3] = $signed({{(PW-VW){cell_rd[3][VW-1]}}, cell_rd[3]})
              * $signed({{(PW-CW){1'b0}}, s2_wx1_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         s3_p_ff[i] <= p_in[i];
      end
      s3_wy0_ff    <= s2_wy0_ff;
      s3_wy1_ff    <= s2_wy1_ff;
      s3_den_ff    <= (2*CW)'(s2_dx_ff) * (2*CW)'(s2_dy_ff);
      s3_status_ff <= s2_status_ff;
   end

   // Stage 4: times y weights.
   logic signed [TW-1:0] t_in [4];
   logic signed [TW-1:0] s4_t_ff [4];
   logic [2*CW-1:0]      s4_den_ff;
   logic [1:0]           s4_status_ff;
   logic                 s4_valid_ff;

   always_comb begin
      t_in[0] = $signed({{(TW-PW){s3_p_ff[0][PW-1]}}, s3_p_ff[0]})
              * $signed({{(TW-CW){1'b0}}, s3_wy0_ff});
      t_in[1] = $signed({{(TW-PW){s3_p_ff[1][PW-1]}}, s3_p_ff[1]})
              * $signed({{(TW-CW){1'b0}}, s3_wy0_ff});
      t_in[2] = $signed({{(TW-PW){s3_p_ff[2][PW-1]}}, s3_p_ff[2]})
              * $signed({{(TW-CW){1'b0}}, s3_wy1_ff});
      t_in[3] = $signed({{(TW-PW){s3_p_ff[3][PW-1]}}, s3_p_ff[3]})
              * $signed({{(TW-CW){1'b0}}, s3_wy1_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         s4_t_ff[i] <= t_in[i];
      end
      s4_den_ff    <= s3_den_ff;
      s4_status_ff <= s3_status_ff;
   end

   // Stage 5: sum of the four terms, split into sign and magnitude.
   logic signed [SW-1:0] sum_in;
   logic [SW-1:0]        abs_in;
   logic [bmi_pkg::MAG_W-1:0] s5_mag_ff;
   logic                 s5_neg_ff;
   logic [2*CW-1:0]      s5_den_ff;
   logic [1:0]           s5_status_ff;
   logic                 s5_valid_ff;

   always_comb begin
      sum_in = SW'(s4_t_ff[0]) + SW'(s4_t_ff[1]) + SW'(s4_t_ff[2]) + SW'(s4_t_ff[3]);
      abs_in = sum_in[SW-1] ? SW'(-sum_in) : SW'(sum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_mag_ff    <= abs_in[bmi_pkg::MAG_W-1:0];
      s5_neg_ff    <= sum_in[SW-1];
      s5_den_ff    <= s4_den_ff;
      s5_status_ff <= s4_status_ff;
   end

   // Stage 6: scale by 256 and add half the denominator for round to nearest.
   logic [bmi_pkg::NUM_W-1:0] s6_num_ff;
   logic [2*CW-1:0]           s6_den_ff;
   bmi_pkg::div_tag_type      s6_tag_ff;
   logic                      s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_num_ff        <= (bmi_pkg::NUM_W'(s5_mag_ff) << 8)
                        + bmi_pkg::NUM_W'(s5_den_ff >> 1);
      s6_den_ff        <= s5_den_ff;
      s6_tag_ff.neg    <= s5_neg_ff;
      s6_tag_ff.status <= s5_status_ff;
   end

   // Division and output register.
   logic                         div_valid;
   logic [bmi_pkg::QUOT_W-1:0]   div_quot;
   bmi_pkg::div_tag_type         div_tag;

   bmi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_tag    (s6_tag_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   logic                         rsp_valid_ff;
   logic [bmi_pkg::RESULT_W-1:0] rsp_value_ff;
   logic [1:0]                   rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= div_tag.neg ? bmi_pkg::RESULT_W'(-div_quot)
                                   : bmi_pkg::RESULT_W'(div_quot);
      rsp_status_ff <= div_tag.status;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = $signed(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;

   // Every response comes from an accepted lookup.
   `BMI_ASSERT(a_rsp_from_lookup, rsp_valid |-> $past(start && !busy && req_command == bmi_pkg::CMD_LOOKUP, bmi_pkg::LATENCY))
   `BMI_ASSERT_NEVER(a_den_zero, s3_valid_ff && s3_den_ff == '0)

endmodule
